/* hw/rtl/twao_pkg.sv */
// Shared types, constants and the CORDIC arctangent table for the tracking-wheel
// arc odometry block. No dependencies; compiled first.
package twao_pkg;

  // Default wrap widths of the wheel and heading deltas
  localparam int DIST_WIDTH_DEF  = 32;
  localparam int ANGLE_WIDTH_DEF = 32;

  // Datapath widths
  localparam int WORD_W    = 64;  // working registers of the sequencer
  localparam int CORDIC_W  = 48;  // rotator vector components
  localparam int ANGLE_Z_W = 28;  // rotator residual angle
  localparam int TURN_W    = 26;  // reduced angle in [0, full turn)

  localparam int CORDIC_STEPS = 24;
  localparam int LOCAL_FRAC   = 8;

  // Fixed-point constants (angles in 1/131072 degree)
  localparam longint INV_GAIN_Q30 = 652032874;
  localparam longint HALF_RAD_Q20 = 149922641;
  localparam longint FULL_TURN    = 47185920;
  localparam longint HALF_TURN    = 23592960;
  localparam longint QUARTER_TURN = 11796480;

  typedef logic signed [WORD_W-1:0] word_t;

  // Right shift applied to a product by the shared multiplier
  typedef enum logic [2:0] {
    SHIFT_20,
    SHIFT_21,
    SHIFT_22,
    SHIFT_30,
    SHIFT_34,
    SHIFT_37,
    SHIFT_38,
    SHIFT_44
  } mul_shift_t;

  // Rounded arctangent of 2^-idx in 1/131072 degree
  function automatic logic [22:0] atan_step(input logic [4:0] idx);
    logic [22:0] v;
    case (idx)
      5'd0:    v = 23'd5898240;
      5'd1:    v = 23'd3481934;
      5'd2:    v = 23'd1839759;
      5'd3:    v = 23'd933890;
      5'd4:    v = 23'd468757;
      5'd5:    v = 23'd234609;
      5'd6:    v = 23'd117332;
      5'd7:    v = 23'd58670;
      5'd8:    v = 23'd29335;
      5'd9:    v = 23'd14668;
      5'd10:   v = 23'd7334;
      5'd11:   v = 23'd3667;
      5'd12:   v = 23'd1833;
      5'd13:   v = 23'd917;
      5'd14:   v = 23'd458;
      5'd15:   v = 23'd229;
      5'd16:   v = 23'd115;
      5'd17:   v = 23'd57;
      5'd18:   v = 23'd29;
      5'd19:   v = 23'd14;
      5'd20:   v = 23'd7;
      5'd21:   v = 23'd4;
      5'd22:   v = 23'd2;
      5'd23:   v = 23'd1;
      default: v = 23'd0;
    endcase
    return v;
  endfunction

endpackage

/* hw/rtl/twao_if.sv */
// Valid/ready channels of the odometry block: sensor sample in, pose out.
// No dependencies.
interface twao_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] heading_reading;
  logic signed [31:0] vertical_distance;
  logic signed [31:0] horizontal_distance;

  modport source (output valid, heading_reading, vertical_distance, horizontal_distance,
                  input ready);
  modport sink (input valid, heading_reading, vertical_distance, horizontal_distance,
                output ready);
endinterface

interface twao_pose_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] pose_x;
  logic signed [31:0] pose_y;
  logic signed [31:0] pose_heading;

  modport source (output valid, pose_x, pose_y, pose_heading, input ready);
  modport sink (input valid, pose_x, pose_y, pose_heading, output ready);
endinterface

/* hw/rtl/twao_mul.sv */
// Shared sign-magnitude multiplier: 48 x 32 bit magnitudes, 16 bits a cycle,
// product shifted right and truncated toward zero. Depends on twao_pkg.
module twao_mul (
  input  logic                clk,
  input  logic                rst,
  input  logic                start,
  input  twao_pkg::word_t     a,
  input  twao_pkg::word_t     b,
  input  twao_pkg::mul_shift_t sh,
  output logic                done,
  output twao_pkg::word_t     p
);
  import twao_pkg::*;

  localparam int A_W     = 48;
  localparam int B_W     = 32;
  localparam int CHUNK_W = 16;
  localparam int PROD_W  = A_W + B_W;
  localparam int CHUNKS  = A_W / CHUNK_W;

  typedef enum logic [1:0] {M_IDLE, M_RUN, M_FIN} mstate_t;

  mstate_t                  state;
  logic [A_W-1:0]           am;
  logic [B_W-1:0]           bm;
  logic                     neg;
  logic [PROD_W-1:0]        acc;
  logic [1:0]               cnt;
  mul_shift_t               sh_r;
  word_t                    a_mag;
  word_t                    b_mag;
  logic [CHUNK_W+B_W-1:0]   part;
  logic [PROD_W-1:0]        shifted;
  word_t                    mag_res;

  // Magnitudes of the operands
  assign a_mag = a[WORD_W-1] ? -a : a;
  assign b_mag = b[WORD_W-1] ? -b : b;

  // One partial product a cycle, top chunk first
  assign part = am[A_W-1 -: CHUNK_W] * bm;

  // Final truncating shift
  always_comb begin
    case (sh_r)
      SHIFT_20: shifted = acc >> 20;
      SHIFT_21: shifted = acc >> 21;
      SHIFT_22: shifted = acc >> 22;
      SHIFT_30: shifted = acc >> 30;
      SHIFT_34: shifted = acc >> 34;
      SHIFT_37: shifted = acc >> 37;
      SHIFT_38: shifted = acc >> 38;
      SHIFT_44: shifted = acc >> 44;
      default:  shifted = acc;
    endcase
  end
  assign mag_res = word_t'(shifted[WORD_W-1:0]);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= M_IDLE;
      done  <= 1'b0;
    end else begin
      done <= 1'b0;
      case (state)
        M_IDLE: begin
          if (start) begin
            am    <= a_mag[A_W-1:0];
            bm    <= b_mag[B_W-1:0];
            neg   <= a[WORD_W-1] ^ b[WORD_W-1];
            sh_r  <= sh;
            acc   <= '0;
            cnt   <= '0;
            state <= M_RUN;
          end
        end
        M_RUN: begin
          acc <= {acc[PROD_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}}
                 + {{(PROD_W-CHUNK_W-B_W){1'b0}}, part};
          am  <= {am[A_W-CHUNK_W-1:0], {CHUNK_W{1'b0}}};
          cnt <= cnt + 2'd1;
          if (cnt == 2'(CHUNKS - 1)) begin
            state <= M_FIN;
          end
        end
        M_FIN: begin
          p     <= neg ? -mag_res : mag_res;
          done  <= 1'b1;
          state <= M_IDLE;
        end
        default: state <= M_IDLE;
      endcase
    end
  end

endmodule

/* hw/rtl/twao_div.sv */
// Shared unsigned restoring divider, one quotient bit a cycle.
// Gives the quotient. Depends on twao_pkg.
module twao_div (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        start,
  input  logic [twao_pkg::WORD_W-1:0] num,
  input  logic [twao_pkg::WORD_W-1:0] den,
  output logic                        done,
  output logic [twao_pkg::WORD_W-1:0] quo
);
  import twao_pkg::*;

  localparam int CNT_W = $clog2(WORD_W);

  logic              busy;
  logic [CNT_W-1:0]  cnt;
  logic [WORD_W-1:0] den_r;
  logic [WORD_W-1:0] rem;
  logic [WORD_W:0]   trial;
  logic [WORD_W:0]   diff;
  logic              fits;

  // Bring down the next numerator bit and try the subtraction
  assign trial = {rem, quo[WORD_W-1]};
  assign diff  = trial - {1'b0, den_r};
  assign fits  = trial >= {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          rem   <= '0;
          quo   <= num;
          den_r <= den;
          cnt   <= '0;
          busy  <= 1'b1;
        end
      end else begin
        rem <= fits ? diff[WORD_W-1:0] : trial[WORD_W-1:0];
        quo <= {quo[WORD_W-2:0], fits};
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(WORD_W - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/twao_cordic.sv */
// Shared CORDIC rotator: folds a reduced angle into +-90 degrees, then runs
// 24 shift-and-add micro-rotations, one a cycle. Depends on twao_pkg.
module twao_cordic (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 start,
  input  logic signed [twao_pkg::CORDIC_W-1:0] x_in,
  input  logic signed [twao_pkg::CORDIC_W-1:0] y_in,
  input  logic [twao_pkg::TURN_W-1:0]          z_in,
  output logic                                 done,
  output logic signed [twao_pkg::CORDIC_W-1:0] x_out,
  output logic signed [twao_pkg::CORDIC_W-1:0] y_out
);
  import twao_pkg::*;

  localparam logic signed [ANGLE_Z_W-1:0] Z_FULL    = ANGLE_Z_W'(FULL_TURN);
  localparam logic signed [ANGLE_Z_W-1:0] Z_HALF    = ANGLE_Z_W'(HALF_TURN);
  localparam logic signed [ANGLE_Z_W-1:0] Z_QUARTER = ANGLE_Z_W'(QUARTER_TURN);

  logic                         busy;
  logic [4:0]                   idx;
  logic signed [CORDIC_W-1:0]   x;
  logic signed [CORDIC_W-1:0]   y;
  logic signed [ANGLE_Z_W-1:0]  z;
  logic signed [ANGLE_Z_W-1:0]  z_start;
  logic signed [ANGLE_Z_W-1:0]  z_wrap;
  logic signed [ANGLE_Z_W-1:0]  z_fold;
  logic                         flip;
  logic signed [CORDIC_W-1:0]   step_x;
  logic signed [CORDIC_W-1:0]   step_y;
  logic signed [ANGLE_Z_W-1:0]  step_z;

  // Move the angle into [-180, 180), then fold beyond +-90 by negating the vector
  assign z_start = signed'({{(ANGLE_Z_W-TURN_W){1'b0}}, z_in});
  assign z_wrap  = (z_start >= Z_HALF) ? z_start - Z_FULL : z_start;
  assign flip    = (z_wrap > Z_QUARTER) || (z_wrap < -Z_QUARTER);
  assign z_fold  = !flip ? z_wrap : ((z_wrap > 0) ? z_wrap - Z_HALF : z_wrap + Z_HALF);

  // Shift terms of the current micro-rotation
  assign step_x = y >>> idx;
  assign step_y = x >>> idx;
  assign step_z = signed'(ANGLE_Z_W'(atan_step(idx)));

  assign x_out = x;
  assign y_out = y;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (!busy) begin
        if (start) begin
          x    <= flip ? -x_in : x_in;
          y    <= flip ? -y_in : y_in;
          z    <= z_fold;
          idx  <= '0;
          busy <= 1'b1;
        end
      end else begin
        // Rotate towards zero residual angle
        if (!z[ANGLE_Z_W-1]) begin
          x <= x - step_x;
          y <= y + step_y;
          z <= z - step_z;
        end else begin
          x <= x + step_x;
          y <= y - step_y;
          z <= z + step_z;
        end
        idx <= idx + 5'd1;
        if (idx == 5'(CORDIC_STEPS - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

/* hw/rtl/tracking_wheel_arc_odometry_top.sv */
// Two tracking-wheel arc odometry: sequencer, state and pose registers around a
// shared multiplier, divider and CORDIC. Depends on twao_pkg, twao_if, twao_mul,
// twao_div and twao_cordic.
//
//   channel  direction  handshake       payload
//   sample   in         valid / ready   heading_reading, vertical_distance,
//                                        horizontal_distance
//   pose     out        valid / ready   pose_x, pose_y, pose_heading
//   cfg      in         cfg_write       cfg_index, cfg_data (no read-back)
//
// One sample at a time; ready is high only while the sequencer is idle.
// A priming sample goes straight to the finishing step; a sample with no turn skips
// the series, and the rotation too when it does not move; a small turn takes the
// series for sin(h) / h and a half angle beyond half a radian the CORDIC and the
// one divide, for k = sin(h) / h. The sequencer waits on each multiply and pass.
// The finished pose sits in an output register, so the next sample is taken
// while it waits; the sequencer stalls only if a new pose is ready first.
// Synchronous reset clears the pose, the previous readings and the offsets.
module tracking_wheel_arc_odometry_top #(
  parameter int DIST_WIDTH  = twao_pkg::DIST_WIDTH_DEF,
  parameter int ANGLE_WIDTH = twao_pkg::ANGLE_WIDTH_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_write,
  input  logic [7:0]  cfg_index,
  input  logic [15:0] cfg_data,
  twao_sample_if.sink sample,
  twao_pose_if.source pose
);
  import twao_pkg::*;

  localparam logic [7:0] REG_VERTICAL_OFFSET   = 8'd0;
  localparam logic [7:0] REG_HORIZONTAL_OFFSET = 8'd1;
  localparam word_t SMALL_LIMIT = word_t'(64'd1 << 29);
  localparam word_t ONE_Q30     = word_t'(64'd1 << 30);
  localparam word_t ROUND_HALF  = word_t'(64'd1 << (LOCAL_FRAC - 1));

  // Exact floor division by a constant: multiply by ceil(2^n / d), shift by n
  localparam word_t RECIP_6    = word_t'(64'd2863311531);  // n = 34
  localparam word_t RECIP_120  = word_t'(64'd2290649225);  // n = 38
  localparam word_t RECIP_5040 = word_t'(64'd3490513105);  // n = 44
  localparam word_t RECIP_45   = word_t'(64'd3054198967);  // n = 37
  // A full turn is 45 << 20
  localparam int    TURN_SHIFT = 20;

  typedef enum logic [4:0] {
    S_IDLE, S_CHECK, S_HALF, S_H2, S_H4, S_H6, S_D6, S_D120, S_D5040,
    S_SIN_SMALL, S_SIN_MOD, S_SIN_ROT, S_SIN_GAIN, S_K_DIV,
    S_LX_ARC, S_LX_OFS, S_LY_ARC, S_LY_OFS, S_MOVE,
    S_ROT_MOD, S_ROT, S_GAIN_X, S_GAIN_Y, S_UPDATE, S_FINISH
  } state_t;

  state_t state;
  logic   launched;

  // Configuration and state
  logic signed [15:0] vertical_offset;
  logic signed [15:0] horizontal_offset;
  logic [31:0]        last_heading;
  logic [31:0]        last_vertical;
  logic [31:0]        last_horizontal;
  logic [31:0]        prev_heading;
  logic [31:0]        position_x;
  logic [31:0]        position_y;
  logic               primed;

  // Working registers
  word_t dth, dx, dy, h, h2, h4, h6, k, s, lx, ly;
  logic               mod_neg;
  logic [WORD_W-1:0]  mod_mag;

  // Output register
  logic        pose_valid;
  logic [31:0] pose_x_r, pose_y_r, pose_heading_r;

  // Shared unit ports
  logic                       mul_start, mul_done;
  word_t                      mul_a, mul_b, mul_p, mul_p_mag;
  mul_shift_t                 mul_sh;
  logic                       div_start, div_done;
  logic [WORD_W-1:0]          div_num, div_den, div_quo;
  logic                       cor_start, cor_done;
  logic signed [CORDIC_W-1:0] cor_x, cor_y, cor_x_out, cor_y_out;
  logic [TURN_W-1:0]          cor_z;

  // Combinational helpers
  word_t             diff_h, diff_v, diff_x;
  word_t             dth_next, dy_next, dx_next;
  word_t             dth_mag, h_mag, s_mag, rot_ang, rot_mag;
  word_t             prev_ext, rnd_x, rnd_y;
  word_t             mod_q45;
  logic [WORD_W-1:0] mod_rem;
  logic [WORD_W-1:0] fmod_full;
  logic [TURN_W-1:0] fmod_z;

  twao_mul u_mul (
    .clk(clk), .rst(rst), .start(mul_start), .a(mul_a), .b(mul_b), .sh(mul_sh),
    .done(mul_done), .p(mul_p)
  );

  twao_div u_div (
    .clk(clk), .rst(rst), .start(div_start), .num(div_num), .den(div_den),
    .done(div_done), .quo(div_quo)
  );

  twao_cordic u_cordic (
    .clk(clk), .rst(rst), .start(cor_start), .x_in(cor_x), .y_in(cor_y), .z_in(cor_z),
    .done(cor_done), .x_out(cor_x_out), .y_out(cor_y_out)
  );

  // Deltas since the previous sample, wrapped to their configured widths
  assign diff_h = word_t'(signed'(sample.heading_reading))
                  - word_t'(signed'(last_heading));
  assign diff_v = word_t'(signed'(sample.vertical_distance))
                  - word_t'(signed'(last_vertical));
  assign diff_x = word_t'(signed'(sample.horizontal_distance))
                  - word_t'(signed'(last_horizontal));
  assign dth_next = {{(WORD_W-ANGLE_WIDTH){diff_h[ANGLE_WIDTH-1]}},
                     diff_h[ANGLE_WIDTH-1:0]};
  assign dy_next  = {{(WORD_W-DIST_WIDTH){diff_v[DIST_WIDTH-1]}}, diff_v[DIST_WIDTH-1:0]};
  assign dx_next  = {{(WORD_W-DIST_WIDTH){diff_x[DIST_WIDTH-1]}}, diff_x[DIST_WIDTH-1:0]};

  // Magnitudes and the final rotation angle, -(2 * previous heading + dth)
  assign mul_p_mag = mul_p[WORD_W-1] ? -mul_p : mul_p;
  assign dth_mag   = dth[WORD_W-1] ? -dth : dth;
  assign h_mag     = h[WORD_W-1] ? -h : h;
  assign s_mag     = s[WORD_W-1] ? -s : s;
  assign prev_ext  = word_t'(signed'(prev_heading));
  assign rot_ang   = -((prev_ext <<< 1) + dth);
  assign rot_mag   = rot_ang[WORD_W-1] ? -rot_ang : rot_ang;

  // Magnitude remainder: subtract the turn count (from the multiplier) times a turn
  assign mod_q45 = (mul_p <<< 5) + (mul_p <<< 3) + (mul_p <<< 2) + mul_p;
  assign mod_rem = mod_mag - (mod_q45 << TURN_SHIFT);

  // Floor modulo one full turn from the magnitude remainder
  assign fmod_full = (mod_neg && mod_mag != '0) ? WORD_W'(FULL_TURN) - mod_mag : mod_mag;
  assign fmod_z    = fmod_full[TURN_W-1:0];

  // Round half up from the local fraction bits
  assign rnd_x = (lx + ROUND_HALF) >>> LOCAL_FRAC;
  assign rnd_y = (ly + ROUND_HALF) >>> LOCAL_FRAC;

  assign sample.ready      = (state == S_IDLE);
  assign pose.valid        = pose_valid;
  assign pose.pose_x       = pose_x_r;
  assign pose.pose_y       = pose_y_r;
  assign pose.pose_heading = pose_heading_r;

  // Sequencer, state and output register
  always_ff @(posedge clk) begin
    if (rst) begin
      state             <= S_IDLE;
      launched          <= 1'b0;
      vertical_offset   <= '0;
      horizontal_offset <= '0;
      last_heading      <= '0;
      last_vertical     <= '0;
      last_horizontal   <= '0;
      position_x        <= '0;
      position_y        <= '0;
      primed            <= 1'b0;
      pose_valid        <= 1'b0;
      mul_start         <= 1'b0;
      div_start         <= 1'b0;
      cor_start         <= 1'b0;
    end else begin
      mul_start <= 1'b0;
      div_start <= 1'b0;
      cor_start <= 1'b0;

      // Configuration writes
      if (cfg_write && cfg_index == REG_VERTICAL_OFFSET) begin
        vertical_offset <= signed'(cfg_data);
      end
      if (cfg_write && cfg_index == REG_HORIZONTAL_OFFSET) begin
        horizontal_offset <= signed'(cfg_data);
      end

      // Drop the pose once transferred
      if (pose_valid && pose.ready) begin
        pose_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (sample.valid) begin
            prev_heading    <= last_heading;
            last_heading    <= sample.heading_reading;
            last_vertical   <= sample.vertical_distance;
            last_horizontal <= sample.horizontal_distance;
            dth             <= dth_next;
            dy              <= dy_next;
            dx              <= dx_next;
            primed          <= 1'b1;
            state           <= primed ? S_CHECK : S_FINISH;
          end
        end
        S_CHECK: begin
          if (dth == '0) begin
            lx    <= dx <<< LOCAL_FRAC;
            ly    <= dy <<< LOCAL_FRAC;
            state <= S_MOVE;
          end else begin
            state <= S_HALF;
          end
        end
        // Half angle in radians, Q30
        S_HALF: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= dth; mul_b <= word_t'(HALF_RAD_Q20);
            mul_sh <= SHIFT_20; launched <= 1'b1;
          end else if (mul_done) begin
            h <= mul_p; launched <= 1'b0;
            state <= (mul_p_mag <= SMALL_LIMIT) ? S_H2 : S_SIN_MOD;
          end
        end
        // Powers of h for the series of sin(h)/h
        S_H2: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h; mul_b <= h; mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            h2 <= mul_p; launched <= 1'b0; state <= S_H4;
          end
        end
        S_H4: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h2; mul_b <= h2; mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            h4 <= mul_p; launched <= 1'b0; state <= S_H6;
          end
        end
        S_H6: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h4; mul_b <= h2; mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            h6 <= mul_p; launched <= 1'b0; state <= S_D6;
          end
        end
        // Series terms by reciprocal multiplication
        S_D6: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h2; mul_b <= RECIP_6; mul_sh <= SHIFT_34;
            launched <= 1'b1;
          end else if (mul_done) begin
            k <= ONE_Q30 - mul_p; launched <= 1'b0; state <= S_D120;
          end
        end
        S_D120: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h4; mul_b <= RECIP_120; mul_sh <= SHIFT_38;
            launched <= 1'b1;
          end else if (mul_done) begin
            k <= k + mul_p; launched <= 1'b0; state <= S_D5040;
          end
        end
        S_D5040: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h6; mul_b <= RECIP_5040; mul_sh <= SHIFT_44;
            launched <= 1'b1;
          end else if (mul_done) begin
            k <= k - mul_p; launched <= 1'b0; state <= S_SIN_SMALL;
          end
        end
        S_SIN_SMALL: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= h; mul_b <= k; mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            s <= mul_p; launched <= 1'b0; state <= S_LX_ARC;
          end
        end
        // Large half angle: sine from the rotator, then k = sin(h) / h
        S_SIN_MOD: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(dth_mag >> TURN_SHIFT); mul_b <= RECIP_45;
            mul_sh <= SHIFT_37; mod_mag <= dth_mag; mod_neg <= dth[WORD_W-1];
            launched <= 1'b1;
          end else if (mul_done) begin
            mod_mag <= mod_rem; launched <= 1'b0; state <= S_SIN_ROT;
          end
        end
        S_SIN_ROT: begin
          if (!launched) begin
            cor_start <= 1'b1; cor_x <= CORDIC_W'(ONE_Q30); cor_y <= '0; cor_z <= fmod_z;
            launched <= 1'b1;
          end else if (cor_done) begin
            launched <= 1'b0; state <= S_SIN_GAIN;
          end
        end
        S_SIN_GAIN: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(cor_y_out); mul_b <= word_t'(INV_GAIN_Q30);
            mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            s <= mul_p; launched <= 1'b0; state <= S_K_DIV;
          end
        end
        S_K_DIV: begin
          if (!launched) begin
            div_start <= 1'b1; div_num <= s_mag << 30; div_den <= h_mag; launched <= 1'b1;
          end else if (div_done) begin
            k <= (s[WORD_W-1] != h[WORD_W-1]) ? -signed'(div_quo) : signed'(div_quo);
            launched <= 1'b0; state <= S_LX_ARC;
          end
        end
        // Local move: delta * k plus offset * 2 sin(h), with 8 fraction bits
        S_LX_ARC: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= dx; mul_b <= k; mul_sh <= SHIFT_22; launched <= 1'b1;
          end else if (mul_done) begin
            lx <= mul_p; launched <= 1'b0; state <= S_LX_OFS;
          end
        end
        S_LX_OFS: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(horizontal_offset); mul_b <= s;
            mul_sh <= SHIFT_21; launched <= 1'b1;
          end else if (mul_done) begin
            lx <= lx + mul_p; launched <= 1'b0; state <= S_LY_ARC;
          end
        end
        S_LY_ARC: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= dy; mul_b <= k; mul_sh <= SHIFT_22; launched <= 1'b1;
          end else if (mul_done) begin
            ly <= mul_p; launched <= 1'b0; state <= S_LY_OFS;
          end
        end
        S_LY_OFS: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(vertical_offset); mul_b <= s;
            mul_sh <= SHIFT_21; launched <= 1'b1;
          end else if (mul_done) begin
            ly <= ly + mul_p; launched <= 1'b0; state <= S_MOVE;
          end
        end
        // Skip the rotation for a zero local move
        S_MOVE: begin
          state <= (lx == '0 && ly == '0) ? S_FINISH : S_ROT_MOD;
        end
        S_ROT_MOD: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(rot_mag >> TURN_SHIFT); mul_b <= RECIP_45;
            mul_sh <= SHIFT_37; mod_mag <= rot_mag; mod_neg <= rot_ang[WORD_W-1];
            launched <= 1'b1;
          end else if (mul_done) begin
            mod_mag <= mod_rem; launched <= 1'b0; state <= S_ROT;
          end
        end
        S_ROT: begin
          if (!launched) begin
            cor_start <= 1'b1; cor_x <= lx[CORDIC_W-1:0]; cor_y <= ly[CORDIC_W-1:0];
            cor_z <= fmod_z; launched <= 1'b1;
          end else if (cor_done) begin
            launched <= 1'b0; state <= S_GAIN_X;
          end
        end
        S_GAIN_X: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(cor_x_out); mul_b <= word_t'(INV_GAIN_Q30);
            mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            lx <= mul_p; launched <= 1'b0; state <= S_GAIN_Y;
          end
        end
        S_GAIN_Y: begin
          if (!launched) begin
            mul_start <= 1'b1; mul_a <= word_t'(cor_y_out); mul_b <= word_t'(INV_GAIN_Q30);
            mul_sh <= SHIFT_30; launched <= 1'b1;
          end else if (mul_done) begin
            ly <= mul_p; launched <= 1'b0; state <= S_UPDATE;
          end
        end
        // Advance the pose, wrapping
        S_UPDATE: begin
          position_x <= position_x + rnd_x[31:0];
          position_y <= position_y + rnd_y[31:0];
          state      <= S_FINISH;
        end
        // Hold until the output register is free
        S_FINISH: begin
          if (!pose_valid || pose.ready) begin
            pose_valid     <= 1'b1;
            pose_x_r       <= position_x;
            pose_y_r       <= position_y;
            pose_heading_r <= last_heading;
            state          <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // The pose cannot move before the priming sample
  a_prime_pose: assert property (@(posedge clk) disable iff (rst)
    !primed |-> (position_x == '0 && position_y == '0))
    else $error("pose moved before priming sample");

  // Only one shared unit launched at a time
  a_one_unit: assert property (@(posedge clk) disable iff (rst)
    $countones({mul_start, div_start, cor_start}) <= 1)
    else $error("two shared units launched together");

  // A transfer in closes the input until the sequencer finishes
  a_busy_after_take: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready |=> !sample.ready)
    else $error("sample taken while busy");

  // A pose is loaded only from the finishing step
  a_pose_from_finish: assert property (@(posedge clk) disable iff (rst)
    $rose(pose.valid) |-> $past(state) == S_FINISH)
    else $error("pose presented outside finishing step");

endmodule

/* sim/tracking_wheel_arc_odometry_top_tb.sv */
// Self-checking bench for the two tracking-wheel arc odometry block.
// Depends on twao_pkg, twao_if and the block's RTL; it predicts every pose and checks it.
`timescale 1ns / 1ps

module tracking_wheel_arc_odometry_top_tb;
  import twao_pkg::*;

  localparam logic [7:0] REG_VERT_OFFSET = 8'd0;
  localparam logic [7:0] REG_HORZ_OFFSET = 8'd1;
  localparam logic [7:0] REG_UNUSED      = 8'd7;
  localparam int SETTLE_CYCLES = 500;
  localparam longint ATAN_TAB [CORDIC_STEPS] = '{
    5898240, 3481934, 1839759, 933890, 468757, 234609, 117332, 58670,
    29335, 14668, 7334, 3667, 1833, 917, 458, 229, 115, 57, 29, 14, 7, 4, 2, 1
  };

  typedef struct packed {
    logic [31:0] heading;
    logic [31:0] vert;
    logic [31:0] horz;
  } sample_t;

  typedef struct packed {
    logic [31:0] x;
    logic [31:0] y;
    logic [31:0] heading;
  } pose_t;

  logic clk;
  logic rst;
  logic cfg_write;
  logic [7:0] cfg_index;
  logic [15:0] cfg_data;

  twao_sample_if sample_ch ();
  twao_pose_if   pose_ch ();

  tracking_wheel_arc_odometry_top DUT (
    .clk       (clk),
    .rst       (rst),
    .cfg_write (cfg_write),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .sample    (sample_ch),
    .pose      (pose_ch)
  );

  sample_t samples_pending [$];
  pose_t   poses_expected [$];
  int mismatches;
  bit idle_off;
  bit rx_hold_go;
  bit rx_hold;

  // Predictor state
  logic signed [15:0] vert_off, horz_off;
  logic [31:0] prev_head, prev_vert, prev_horz, pos_x, pos_y;
  bit primed;

  // Stimulus generator history
  logic [31:0] gen_head, gen_vert, gen_horz;

  initial clk = 1'b0;
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  function automatic logic [63:0] mag(longint v);
    return (v < 0) ? 64'(-v) : 64'(v);
  endfunction

  // Full-width product shifted right, truncated toward zero
  function automatic longint mul_trunc(longint a, longint b, int sh);
    logic [127:0] p;
    logic [63:0] r;
    p = {64'd0, mag(a)} * {64'd0, mag(b)};
    r = 64'(p >> sh) & 64'h7FFF_FFFF_FFFF_FFFF;
    return ((a < 0) != (b < 0)) ? -longint'(r) : longint'(r);
  endfunction

  // Counter-clockwise CORDIC rotation, angle in 1/131072 degree, gain removed
  function automatic void cordic_rotate(inout longint x, inout longint y, input longint ang);
    longint cx, cy, z, dx, dy;
    cx = x;
    cy = y;
    z = ((ang % FULL_TURN) + FULL_TURN) % FULL_TURN;
    if (z >= HALF_TURN) z -= FULL_TURN;
    if (z > QUARTER_TURN || z < -QUARTER_TURN) begin
      z += (z > 0) ? -HALF_TURN : HALF_TURN;
      cx = -cx;
      cy = -cy;
    end
    for (int i = 0; i < CORDIC_STEPS; i++) begin
      dx = cy >>> i;
      dy = cx >>> i;
      if (z >= 0) begin
        cx -= dx; cy += dy; z -= ATAN_TAB[i];
      end else begin
        cx += dx; cy -= dy; z += ATAN_TAB[i];
      end
    end
    x = mul_trunc(cx, INV_GAIN_Q30, 30);
    y = mul_trunc(cy, INV_GAIN_Q30, 30);
  endfunction

  // Advance the pose by one sample and return what the block should report
  function automatic pose_t advance_pose(sample_t s);
    logic signed [31:0] d32;
    longint prev, dth, dvert, dhorz, lx, ly, h, k, sn, h2, h4, h6, cx, sy;
    logic [63:0] q;
    pose_t p;
    if (primed) begin
      prev = longint'($signed(prev_head));
      d32 = s.heading - prev_head; dth = d32;
      d32 = s.vert - prev_vert;    dvert = d32;
      d32 = s.horz - prev_horz;    dhorz = d32;
      if (dth == 0) begin
        lx = dhorz * 256;
        ly = dvert * 256;
      end else begin
        h = mul_trunc(dth, HALF_RAD_Q20, 20);
        if (mag(h) <= (64'd1 << 29)) begin
          h2 = (h * h) >>> 30;
          h4 = (h2 * h2) >>> 30;
          h6 = (h4 * h2) >>> 30;
          k = (longint'(1) << 30) - h2 / 6 + h4 / 120 - h6 / 5040;
          sn = mul_trunc(h, k, 30);
        end else begin
          cx = longint'(1) << 30;
          sy = 0;
          cordic_rotate(cx, sy, dth);
          sn = sy;
          q = (mag(sn) << 30) / mag(h);
          k = ((sn < 0) != (h < 0)) ? -longint'(q) : longint'(q);
        end
        lx = mul_trunc(dhorz, k, 22) + mul_trunc(longint'(horz_off), sn, 21);
        ly = mul_trunc(dvert, k, 22) + mul_trunc(longint'(vert_off), sn, 21);
      end
      // A zero local move leaves the pose alone
      if (lx != 0 || ly != 0) begin
        cordic_rotate(lx, ly, -(2 * prev + dth));
        lx = (lx + 128) >>> 8;
        ly = (ly + 128) >>> 8;
        pos_x = pos_x + lx[31:0];
        pos_y = pos_y + ly[31:0];
      end
    end
    primed = 1'b1;
    prev_head = s.heading;
    prev_vert = s.vert;
    prev_horz = s.horz;
    p.x = pos_x;
    p.y = pos_y;
    p.heading = s.heading;
    return p;
  endfunction

  // Mostly no idling, some short gaps, a few long ones
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (idle_off || r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 15);
    return $urandom_range(30, 120);
  endfunction

  // Sample driver: hold valid until the transfer, then offer the next item
  int tx_gap = 0;
  always @(posedge clk) begin
    bit took;
    if (rst) begin
      sample_ch.valid <= 1'b0;
    end else begin
      took = sample_ch.valid && sample_ch.ready;
      if (took) begin
        poses_expected.push_back(advance_pose(samples_pending.pop_front()));
        tx_gap = idle_len();
      end
      if (!sample_ch.valid || took) begin
        if (tx_gap > 0 || samples_pending.size() == 0) begin
          sample_ch.valid <= 1'b0;
          if (tx_gap > 0) tx_gap--;
        end else begin
          sample_ch.valid <= 1'b1;
          sample_ch.heading_reading <= samples_pending[0].heading;
          sample_ch.vertical_distance <= samples_pending[0].vert;
          sample_ch.horizontal_distance <= samples_pending[0].horz;
        end
      end
    end
  end

  // Pose monitor: compare each transfer with the oldest prediction
  int rx_gap = 0;
  always @(posedge clk) begin
    pose_t want;
    if (rst) begin
      pose_ch.ready <= 1'b0;
    end else begin
      if (pose_ch.valid && pose_ch.ready) begin
        if (poses_expected.size() == 0) begin
          mismatches++;
          if (mismatches <= 10)
            $display("unexpected pose x=%0d y=%0d h=%0d", pose_ch.pose_x, pose_ch.pose_y,
                     pose_ch.pose_heading);
        end else begin
          want = poses_expected.pop_front();
          if (pose_ch.pose_x !== want.x || pose_ch.pose_y !== want.y ||
              pose_ch.pose_heading !== want.heading) begin
            mismatches++;
            if (mismatches <= 10)
              $display("pose differs: expected x=%0d y=%0d h=%0d, got x=%0d y=%0d h=%0d",
                       $signed(want.x), $signed(want.y), $signed(want.heading),
                       pose_ch.pose_x, pose_ch.pose_y, pose_ch.pose_heading);
          end
        end
        rx_gap = idle_len();
      end
      if (rx_hold) begin
        pose_ch.ready <= 1'b0;
      end else if (rx_gap > 0) begin
        pose_ch.ready <= 1'b0;
        rx_gap--;
      end else begin
        pose_ch.ready <= 1'b1;
      end
    end
  end

  // Long receiver hold-off while the sender keeps offering samples
  initial begin
    rx_hold = 1'b0;
    wait (rx_hold_go);
    rx_hold = 1'b1;
    repeat (3000) @(posedge clk);
    rx_hold = 1'b0;
  end

  task automatic write_reg(logic [7:0] idx, logic [15:0] val);
    @(posedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx == REG_VERT_OFFSET) vert_off = val;
    else if (idx == REG_HORZ_OFFSET) horz_off = val;
    cfg_write <= 1'b0;
  endtask

  task automatic push_sample(logic [31:0] hd, logic [31:0] vt, logic [31:0] hz);
    sample_t s;
    s.heading = hd;
    s.vert = vt;
    s.horz = hz;
    samples_pending.push_back(s);
    gen_head = hd;
    gen_vert = vt;
    gen_horz = hz;
  endtask

  function automatic logic [31:0] small_step(int span);
    return 32'($urandom_range(0, 2 * span) - span);
  endfunction

  // Random samples: mostly plausible motion, some wild jumps and noise
  task automatic push_random(int n);
    int r;
    for (int i = 0; i < n; i++) begin
      r = $urandom_range(0, 99);
      if (r < 10)
        push_sample(gen_head, gen_vert, gen_horz);
      else if (r < 30)
        push_sample(gen_head, gen_vert + small_step(4000), gen_horz + small_step(4000));
      else if (r < 70)
        push_sample(gen_head + small_step(20 * 65536), gen_vert + small_step(8000),
                    gen_horz + small_step(8000));
      else if (r < 85)
        push_sample(gen_head + small_step(180 * 65536), gen_vert + small_step(20000),
                    gen_horz + small_step(20000));
      else if (r < 93)
        push_sample($urandom, $urandom, $urandom);
      else
        push_sample(gen_head + $urandom, gen_vert + $urandom, gen_horz + $urandom);
    end
  endtask

  task automatic drain();
    while (samples_pending.size() != 0 || poses_expected.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  initial begin
    rst = 1'b1;
    cfg_write = 1'b0;
    cfg_index = '0;
    cfg_data = '0;
    sample_ch.valid = 1'b0;
    sample_ch.heading_reading = '0;
    sample_ch.vertical_distance = '0;
    sample_ch.horizontal_distance = '0;
    pose_ch.ready = 1'b0;
    mismatches = 0;
    idle_off = 1'b0;
    rx_hold_go = 1'b0;
    vert_off = '0;
    horz_off = '0;
    prev_head = '0;
    prev_vert = '0;
    prev_horz = '0;
    pos_x = '0;
    pos_y = '0;
    primed = 1'b0;
    gen_head = '0;
    gen_vert = '0;
    gen_horz = '0;
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // Directed: priming sample, zero moves, wrapped deltas, half-radian edge, big turns
    write_reg(REG_VERT_OFFSET, 16'sd1500);
    write_reg(REG_HORZ_OFFSET, -16'sd700);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000);
    push_sample(32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'h0000_0000, 32'h0000_0000, 32'h0000_0000);
    push_sample(32'h0000_0001, 32'h0000_0100, 32'h0000_0000);
    push_sample(32'h0000_0000, 32'h0000_0100, 32'h0000_0100);
    push_sample(32'd3754936, 32'd5000, 32'd100);
    push_sample(32'd7509873, 32'd9000, 32'd150);
    push_sample(32'd3754937, 32'd4000, 32'd50);
    push_sample(32'd0, 32'd0, 32'd0);
    push_sample(32'd90 * 65536, 32'd10000, 32'd0);
    push_sample(32'd270 * 65536, 32'd20000, 32'd2000);
    push_sample(-32'sd90 * 65536, 32'd20000, 32'd2000);
    push_sample(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF);
    push_sample(32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0000);
    push_sample(32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF);
    push_sample(32'h1234_5678, 32'hDEAD_BEEF, 32'h0F0F_F0F0);
    push_sample(gen_head + 32'd1, gen_vert, gen_horz);
    drain();

    // Extreme offsets, with a long receiver hold-off early on
    write_reg(REG_VERT_OFFSET, 16'sh7FFF);
    write_reg(REG_HORZ_OFFSET, 16'sh8000);
    rx_hold_go = 1'b1;
    push_random(400);
    drain();

    // Opposite extremes with no idling; an unused index must change nothing
    write_reg(REG_VERT_OFFSET, 16'sh8000);
    write_reg(REG_HORZ_OFFSET, 16'sh7FFF);
    write_reg(REG_UNUSED, 16'hFFFF);
    idle_off = 1'b1;
    push_random(400);
    drain();
    idle_off = 1'b0;

    // Zero offsets, then random ones
    write_reg(REG_VERT_OFFSET, 16'd0);
    write_reg(REG_HORZ_OFFSET, 16'd0);
    push_random(380);
    drain();
    for (int ph = 0; ph < 2; ph++) begin
      write_reg(REG_VERT_OFFSET, 16'($urandom));
      write_reg(REG_HORZ_OFFSET, 16'($urandom));
      push_random(385);
      drain();
    end

    if (mismatches == 0) $display("tracking_wheel_arc_odometry_top: match");
    else $display("tracking_wheel_arc_odometry_top: mismatch");
    $finish;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("tracking_wheel_arc_odometry_top: mismatch");
    $finish;
  end

endmodule
